// ----- rtl/cdsrs_pkg.sv -----
// Package for the optical-drive sector read sequencer.
// Action codes, event codes, queue entry type. No dependencies.
package cdsrs_pkg;
	localparam logic [1:0] MODE_READ = 2'd0;
	localparam logic [1:0] MODE_IRQ  = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;
	localparam logic [1:0] MODE_STOP = 2'd3;

	localparam logic [2:0] IRQ_DATA  = 3'd1;
	localparam logic [2:0] IRQ_DONE  = 3'd2;
	localparam logic [2:0] IRQ_ERROR = 3'd5;

	localparam logic [3:0] ACT_ACK      = 4'd0;
	localparam logic [3:0] ACT_FLUSH    = 4'd1;
	localparam logic [3:0] ACT_READ     = 4'd2;
	localparam logic [3:0] ACT_PAUSE    = 4'd3;
	localparam logic [3:0] ACT_NOP      = 4'd4;
	localparam logic [3:0] ACT_CAP_C    = 4'd5;
	localparam logic [3:0] ACT_CAP_D    = 4'd6;
	localparam logic [3:0] ACT_COPY     = 4'd7;
	localparam logic [3:0] ACT_COMPLETE = 4'd8;
	localparam logic [3:0] ACT_RECOVER  = 4'd9;

	localparam int SECTOR_BYTES = 2048;
	localparam int PREFETCH_WINDOW = 21;
	localparam logic [23:0] SECTOR_RESET = 24'd16;

	typedef struct packed {
		logic [1:0]  mode;
		logic [23:0] file_start_sector;
		logic [29:0] file_size;
		logic [29:0] read_offset;
		logic [29:0] request_length;
		logic [31:0] dest_address;
		logic        from_completion_context;
		logic [2:0]  interrupt_kind;
		logic        drive_error;
		logic [23:0] header_sector;
		logic [29:0] room;
	} cdsrs_evt_t;

	typedef struct packed {
		logic [3:0]  action;
		logic [23:0] sector;
		logic [10:0] source_offset;
		logic [31:0] target_address;
		logic [11:0] byte_count;
		logic [29:0] accepted_length;
		logic        last;
	} cdsrs_res_t;
endpackage

// ----- rtl/cdsrs_front.sv -----
// Front end: takes event requests, precomputes the clamp room, queues them.
// Depends on cdsrs_pkg.
module cdsrs_front import cdsrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cdsrs_evt_t  in_evt,
	output logic        q_valid,
	input  logic        q_ready,
	output cdsrs_evt_t  q_evt
);
	cdsrs_evt_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cdsrs_evt_t e;
	logic push, pop;

	always_comb begin
		e = in_evt;
		e.room = (in_evt.read_offset < in_evt.file_size) ?
			in_evt.file_size - in_evt.read_offset : 30'd0;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_evt    = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ----- rtl/cdsrs_back.sv -----
// Back end: runs one event against the controller state, emits results.
// Depends on cdsrs_pkg.
module cdsrs_back import cdsrs_pkg::*; #(
	parameter int RETRY_LIMIT  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        q_valid,
	output logic        q_ready,
	input  cdsrs_evt_t  q_evt,
	output logic        res_valid,
	input  logic        res_ready,
	output cdsrs_res_t  res
);
	localparam int OW = $clog2(SECTOR_BYTES);
	localparam logic [29:0] SB30 = 30'(SECTOR_BYTES);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} st_t;
	st_t st_q;

	logic [15:0] reload_q;
	logic [4:0]  flags_q;
	logic [10:0] coff_q;
	logic [11:0] clen_q;
	logic [29:0] rem_q;
	logic [3:0]  retry_q;
	logic [23:0] want_q, head_q, lastd_q;
	logic [15:0] wd_q;
	logic [31:0] addr_q;
	logic        paused_q, armed_q;
	cdsrs_evt_t  ev_s1;
	cdsrs_res_t  buf_q [6];
	logic [2:0]  n_q, idx_q;

	logic [4:0]  f;
	logic [10:0] co;
	logic [11:0] cl;
	logic [29:0] rm, len;
	logic [3:0]  rc;
	logic [23:0] ws, hs, ld;
	logic [15:0] wd;
	logic [31:0] da;
	logic        pz, ar, hold;
	cdsrs_res_t  ob [6];
	logic [2:0]  n;
	logic [29:0] oacc;
	logic [OW:0] sum;
	logic signed [24:0] diff;

	always_comb begin
		f = flags_q; co = coff_q; cl = clen_q; rm = rem_q; rc = retry_q;
		ws = want_q; hs = head_q; ld = lastd_q; wd = wd_q; da = addr_q;
		pz = paused_q; ar = armed_q; hold = 1'b0;
		n = 3'd0; oacc = 30'd0; len = 30'd0; sum = '0; diff = '0;
		for (int i = 0; i < 6; i++) ob[i] = '0;
		case (ev_s1.mode)
			MODE_READ: begin
				if (f[0] || f[1]) begin
					ob[0].action = ACT_ACK; n = 3'd1;
				end else begin
					len = (ev_s1.room < ev_s1.request_length) ? ev_s1.room
						: ev_s1.request_length;
					oacc = len;
					co = 11'(ev_s1.read_offset[OW-1:0]);
					if (co != 11'd0 || len < SB30) f[3] = 1'b1;
					sum = {1'b0, co[OW-1:0]} + ((len > SB30) ? (OW+1)'(SECTOR_BYTES)
						: len[OW:0]);
					cl = ((len > SB30) || (sum > (OW+1)'(SECTOR_BYTES))) ?
						12'(SECTOR_BYTES - int'(co)) : 12'(len);
					rm = len - 30'(cl);
					rc = 4'd0; pz = 1'b0;
					ws = ev_s1.file_start_sector + 24'(ev_s1.read_offset >> OW);
					f[1] = 1'b1; wd = reload_q; da = ev_s1.dest_address; ar = 1'b1;
					if (hs == ws && f[4] && ev_s1.from_completion_context) begin
						ob[0].action = ACT_COPY; ob[0].source_offset = co;
						ob[0].target_address = da; ob[0].byte_count = cl;
						n = 3'd1;
						if (rm == 30'd0) begin
							wd = 16'd0; f[1] = 1'b0; ar = 1'b0;
							ob[1].action = ACT_COMPLETE; n = 3'd2;
						end else begin
							co = 11'd0; da = da + 32'(cl); f[3] = 1'b0;
							if (rm < SB30) begin cl = 12'(rm); f[3] = 1'b1; end
							else cl = 12'(SECTOR_BYTES);
							rm = rm - 30'(cl);
							ws = ws + 24'd1;
						end
					end
					ob[n].action = ACT_ACK; n = n + 3'd1;
				end
				for (int i = 0; i < 6; i++) ob[i].accepted_length = oacc;
			end
			MODE_IRQ: begin
				if (ev_s1.drive_error) begin
					ar = 1'b0; ob[0].action = ACT_RECOVER; n = 3'd1; hold = 1'b1;
				end else begin
					if (ev_s1.interrupt_kind == IRQ_DONE) begin
						if (pz) begin pz = 1'b0; rc = 4'd0; f[1] = 1'b1; end
					end else if (ev_s1.interrupt_kind == IRQ_DATA) begin
						if (!f[0]) begin
							ob[0].action = ACT_FLUSH; n = 3'd1;
						end else if (f[2]) begin
							f[2] = 1'b0; ob[0].action = ACT_FLUSH;
							f[0] = 1'b0; wd = 16'd0; ld = hs; ar = 1'b0;
							ob[1].action = ACT_COMPLETE; n = 3'd2;
						end else begin
							if (f[3]) ob[0].action = ACT_CAP_C;
							else begin
								ob[0].action = ACT_CAP_D; ob[0].target_address = da;
							end
							n = 3'd1;
							if (ev_s1.header_sector == hs) begin
								wd = reload_q;
								if (f[3]) begin
									f[3] = 1'b0; f[4] = 1'b1;
									ob[1].action = ACT_COPY; ob[1].source_offset = co;
									ob[1].target_address = da; ob[1].byte_count = cl;
									n = 3'd2; co = 11'd0;
								end
								if (rm == 30'd0) begin
									f[0] = 1'b0; wd = 16'd0; ld = hs; ar = 1'b0;
									ob[n].action = ACT_COMPLETE; n = n + 3'd1;
								end else begin
									da = da + 32'(cl);
									if (rm < SB30) begin cl = 12'(rm); f[3] = 1'b1; end
									else cl = 12'(SECTOR_BYTES);
									rm = rm - 30'(cl);
								end
							end else begin
								if (pz) begin pz = 1'b0; rc = 4'd0; end
								else rc = rc + 4'd1;
								ws = hs;
								if (rc >= 4'(RETRY_LIMIT)) begin
									pz = 1'b1; ob[n].action = ACT_PAUSE;
									n = n + 3'd1; hold = 1'b1;
								end else f[1] = 1'b1;
							end
						end
					end else if (ev_s1.interrupt_kind == IRQ_ERROR && f[0]) begin
						ob[0].action = ACT_NOP; n = 3'd1;
						if (pz) begin pz = 1'b0; rc = 4'd0; end
						else rc = rc + 4'd1;
						ws = hs;
						if (rc >= 4'(RETRY_LIMIT)) begin
							pz = 1'b1; ob[1].action = ACT_PAUSE; n = 3'd2; hold = 1'b1;
						end else f[1] = 1'b1;
					end
					if (!hold) begin
						hs = hs + 24'd1;
						if (f[1]) begin
							f[1] = 1'b0; f[4] = 1'b0; f[0] = 1'b1;
							if (hs != ws) begin
								ob[n].action = ACT_FLUSH; n = n + 3'd1;
								hs = ws;
								ob[n].action = ACT_READ; ob[n].sector = ws;
								n = n + 3'd1;
							end
						end
						diff = $signed({1'b0, hs}) - $signed({1'b0, ld});
						if (!f[0] && diff >= 25'(PREFETCH_WINDOW)) begin
							hs = ld;
							ob[n].action = ACT_READ; ob[n].sector = ld;
							n = n + 3'd1;
						end
					end
				end
			end
			MODE_TICK: begin
				if (ar && wd != 16'd0) begin
					wd = wd - 16'd1;
					if (wd == 16'd0) begin
						ar = 1'b0; ob[0].action = ACT_RECOVER; n = 3'd1;
					end
				end
			end
			default: f[2] = 1'b1;
		endcase
		if (n == 3'd0) begin
			ob[0].action = ACT_ACK; n = 3'd1;
		end
		for (int i = 0; i < 6; i++) ob[i].last = (3'(i) == n - 3'd1);
	end

	assign q_ready   = (st_q == S_IDLE);
	assign res_valid = (st_q == S_OUT);
	assign res       = buf_q[idx_q];

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) ev_s1 <= q_evt;
		if (st_q == S_EXEC) for (int i = 0; i < 6; i++) buf_q[i] <= ob[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; reload_q <= 16'd360; flags_q <= '0; coff_q <= '0;
			clen_q <= '0; rem_q <= '0; retry_q <= '0; want_q <= SECTOR_RESET;
			head_q <= SECTOR_RESET; lastd_q <= '0; wd_q <= '0; addr_q <= '0;
			paused_q <= 1'b0; armed_q <= 1'b0; n_q <= '0; idx_q <= '0;
		end else begin
			if (cfg_we) reload_q <= cfg_data;
			case (st_q)
				S_IDLE: if (q_valid) st_q <= S_EXEC;
				S_EXEC: begin
					flags_q <= f; coff_q <= co; clen_q <= cl; rem_q <= rm;
					retry_q <= rc; want_q <= ws; head_q <= hs; lastd_q <= ld;
					wd_q <= wd; addr_q <= da; paused_q <= pz; armed_q <= ar;
					n_q <= n; idx_q <= 3'd0; st_q <= S_OUT;
				end
				S_OUT: if (res_ready) begin
					if (idx_q == n_q - 3'd1) st_q <= S_IDLE;
					else idx_q <= idx_q + 3'd1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/cd_sector_read_sequencer.sv -----
// Optical-drive sector read sequencer, top level.
// A request is queued, then loaded and executed by the back end; results
// go out one per cycle while out_ready is high. The next event is loaded
// after the last result is taken; the 2-entry input queue accepts meanwhile.
// Reset: asynchronous, clears queue and state; reload register resets to 360.
// Depends on cdsrs_pkg, cdsrs_front, cdsrs_back.
module cd_sector_read_sequencer import cdsrs_pkg::*; #(
	parameter int RETRY_LIMIT  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [23:0] file_start_sector,
	input  logic [29:0] file_size,
	input  logic [29:0] read_offset,
	input  logic [29:0] request_length,
	input  logic [31:0] dest_address,
	input  logic        from_completion_context,
	input  logic [2:0]  interrupt_kind,
	input  logic        drive_error,
	input  logic [23:0] header_sector,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  action,
	output logic [23:0] sector,
	output logic [10:0] source_offset,
	output logic [31:0] target_address,
	output logic [11:0] byte_count,
	output logic [29:0] accepted_length,
	output logic        last
);
	cdsrs_evt_t ev, qe;
	cdsrs_res_t r;
	logic qv, qr;

	always_comb begin
		ev = '0;
		ev.mode = mode; ev.file_start_sector = file_start_sector;
		ev.file_size = file_size; ev.read_offset = read_offset;
		ev.request_length = request_length; ev.dest_address = dest_address;
		ev.from_completion_context = from_completion_context;
		ev.interrupt_kind = interrupt_kind; ev.drive_error = drive_error;
		ev.header_sector = header_sector;
	end

	cdsrs_front u_front (.clk, .arst_n, .in_valid, .in_ready, .in_evt(ev),
		.q_valid(qv), .q_ready(qr), .q_evt(qe));

	cdsrs_back #(.RETRY_LIMIT(RETRY_LIMIT)) u_back (
		.clk, .arst_n, .cfg_we, .cfg_data, .q_valid(qv), .q_ready(qr), .q_evt(qe),
		.res_valid(out_valid), .res_ready(out_ready), .res(r));

	assign action = r.action;
	assign sector = r.sector;
	assign source_offset = r.source_offset;
	assign target_address = r.target_address;
	assign byte_count = r.byte_count;
	assign accepted_length = r.accepted_length;
	assign last = r.last;
endmodule

// ----- rtl/cdsrs_checker.sv -----
// Port-level checker for the sector read sequencer, bound to the top level.
// Depends on cdsrs_pkg.
module cdsrs_checker import cdsrs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  action,
	input logic [23:0] sector,
	input logic [11:0] byte_count,
	input logic        last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action))
		else $error("result dropped while stalled");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> action <= ACT_RECOVER)
		else $error("bad action code");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != ACT_COPY |-> byte_count == 12'd0)
		else $error("byte count on non-copy");
	a_sec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != ACT_READ |-> sector == 24'd0)
		else $error("sector on non-read");
	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_PAUSE || action == ACT_RECOVER) |-> last)
		else $error("pause or recovery not final");
endmodule

bind cd_sector_read_sequencer cdsrs_checker u_chk (.clk, .arst_n, .out_valid,
	.out_ready, .action, .sector, .byte_count, .last);

// ----- tb/cd_sector_read_sequencer_checker.sv -----
// Checker for the sector read sequencer: watches both channels and the reload write,
// predicts the actions of each accepted request and compares them in order.
// Depends on cdsrs_pkg.
`timescale 1ns / 100ps
module cd_sector_read_sequencer_checker import cdsrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [23:0] file_start_sector,
	input  logic [29:0] file_size,
	input  logic [29:0] read_offset,
	input  logic [29:0] request_length,
	input  logic [31:0] dest_address,
	input  logic        from_completion_context,
	input  logic [2:0]  interrupt_kind,
	input  logic        drive_error,
	input  logic [23:0] header_sector,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  action,
	input  logic [23:0] sector,
	input  logic [10:0] source_offset,
	input  logic [31:0] target_address,
	input  logic [11:0] byte_count,
	input  logic [29:0] accepted_length,
	input  logic        last,
	output int          fail_count,
	output int          pending,
	output logic [23:0] head_hint
);
	localparam int SECTOR = 2048;
	localparam int RETRIES = 4;
	localparam logic [4:0] F_READING = 5'h01;
	localparam logic [4:0] F_PENDING = 5'h02;
	localparam logic [4:0] F_STOP    = 5'h04;
	localparam logic [4:0] F_PARTIAL = 5'h08;
	localparam logic [4:0] F_CACHED  = 5'h10;

	logic [15:0] reload;
	logic [4:0]  flags;
	logic [10:0] c_off;
	logic [11:0] c_len;
	logic [29:0] remaining;
	logic [3:0]  retries;
	logic [23:0] wanted, head, delivered;
	logic [15:0] wdog;
	logic [31:0] daddr;
	bit          paused, armed;
	logic [29:0] acc;
	cdsrs_res_t  actions[$];
	cdsrs_res_t  awaited[$];

	function automatic void put(logic [3:0] a, logic [23:0] s, logic [10:0] so,
			logic [31:0] t, logic [11:0] n);
		cdsrs_res_t r;
		if (actions.size() >= 6)
			return;
		r.action = a;
		r.sector = s;
		r.source_offset = so;
		r.target_address = t;
		r.byte_count = n;
		r.accepted_length = acc;
		r.last = 1'b0;
		actions.push_back(r);
	endfunction

	function automatic void next_chunk();
		if (remaining < SECTOR) begin
			c_len = remaining[11:0];
			flags |= F_PARTIAL;
		end else begin
			c_len = 12'(SECTOR);
		end
		remaining = remaining - 30'(c_len);
	endfunction

	function automatic void bump_retry();
		if (paused) begin
			paused = 0;
			retries = 0;
		end else begin
			retries = retries + 4'd1;
		end
		wanted = head;
	endfunction

	function automatic void advance();
		int diff;
		head = head + 24'd1;
		if (flags & F_PENDING) begin
			flags = (flags & ~(F_PENDING | F_CACHED)) | F_READING;
			if (head != wanted) begin
				put(ACT_FLUSH, 0, 0, 0, 0);
				head = wanted;
				put(ACT_READ, wanted, 0, 0, 0);
			end
		end
		diff = int'({8'd0, head}) - int'({8'd0, delivered});
		if ((flags & F_READING) || diff < PREFETCH_WINDOW)
			return;
		head = delivered;
		put(ACT_READ, delivered, 0, 0, 0);
	endfunction

	function automatic void complete();
		flags &= ~F_READING;
		wdog = 0;
		delivered = head;
		armed = 0;
		put(ACT_COMPLETE, 0, 0, 0, 0);
	endfunction

	function automatic void read_request();
		logic [29:0] room, len;
		if (flags & (F_READING | F_PENDING)) begin
			put(ACT_ACK, 0, 0, 0, 0);
			return;
		end
		room = (read_offset < file_size) ? file_size - read_offset : 30'd0;
		len = request_length;
		if (room < len)
			len = room;
		acc = len;
		c_off = read_offset[10:0];
		if (c_off != 0 || len < SECTOR)
			flags |= F_PARTIAL;
		if (32'(c_off) + 32'(len) > SECTOR)
			c_len = 12'(SECTOR - int'(c_off));
		else
			c_len = len[11:0];
		remaining = len - 30'(c_len);
		retries = 0;
		paused = 0;
		wanted = file_start_sector + 24'(read_offset[29:11]);
		flags |= F_PENDING;
		wdog = reload;
		daddr = dest_address;
		armed = 1;
		if (head == wanted && (flags & F_CACHED) && from_completion_context) begin
			put(ACT_COPY, 0, c_off, daddr, c_len);
			if (remaining == 0) begin
				wdog = 0;
				flags &= ~F_PENDING;
				armed = 0;
				put(ACT_COMPLETE, 0, 0, 0, 0);
			end else begin
				c_off = 0;
				daddr = daddr + 32'(c_len);
				flags &= ~F_PARTIAL;
				next_chunk();
				wanted = wanted + 24'd1;
			end
		end
		put(ACT_ACK, 0, 0, 0, 0);
	endfunction

	function automatic bit miss_or_error();
		bump_retry();
		if (retries >= RETRIES) begin
			paused = 1;
			put(ACT_PAUSE, 0, 0, 0, 0);
			return 1;
		end
		flags |= F_PENDING;
		return 0;
	endfunction

	function automatic void drive_irq();
		if (drive_error) begin
			armed = 0;
			put(ACT_RECOVER, 0, 0, 0, 0);
			return;
		end
		if (interrupt_kind == IRQ_DONE) begin
			if (paused) begin
				paused = 0;
				retries = 0;
				flags |= F_PENDING;
			end
		end else if (interrupt_kind == IRQ_DATA) begin
			if (!(flags & F_READING)) begin
				put(ACT_FLUSH, 0, 0, 0, 0);
			end else if (flags & F_STOP) begin
				flags &= ~F_STOP;
				put(ACT_FLUSH, 0, 0, 0, 0);
				complete();
			end else begin
				if (flags & F_PARTIAL)
					put(ACT_CAP_C, 0, 0, 0, 0);
				else
					put(ACT_CAP_D, 0, 0, daddr, 0);
				if (header_sector == head) begin
					wdog = reload;
					if (flags & F_PARTIAL) begin
						flags = (flags & ~F_PARTIAL) | F_CACHED;
						put(ACT_COPY, 0, c_off, daddr, c_len);
						c_off = 0;
					end
					if (remaining == 0) begin
						complete();
					end else begin
						daddr = daddr + 32'(c_len);
						next_chunk();
					end
				end else if (miss_or_error()) begin
					return;
				end
			end
		end else if (interrupt_kind == IRQ_ERROR && (flags & F_READING)) begin
			put(ACT_NOP, 0, 0, 0, 0);
			if (miss_or_error())
				return;
		end
		advance();
	endfunction

	function automatic void predict();
		actions.delete();
		acc = 0;
		case (mode)
			MODE_READ: read_request();
			MODE_IRQ:  drive_irq();
			MODE_TICK: begin
				if (armed && wdog != 0) begin
					wdog = wdog - 16'd1;
					if (wdog == 0) begin
						armed = 0;
						put(ACT_RECOVER, 0, 0, 0, 0);
					end
				end
			end
			default: flags |= F_STOP;
		endcase
		if (actions.size() == 0)
			put(ACT_ACK, 0, 0, 0, 0);
		actions[actions.size() - 1].last = 1'b1;
		foreach (actions[i])
			awaited.push_back(actions[i]);
	endfunction

	task automatic compare();
		cdsrs_res_t e;
		if (awaited.size() == 0) begin
			$error("unexpected action %0d", action);
			fail_count++;
			return;
		end
		e = awaited.pop_front();
		if (action !== e.action) begin
			$error("action: expected %0d, got %0d", e.action, action);
			fail_count++;
		end
		if (sector !== e.sector) begin
			$error("sector: expected %0h, got %0h", e.sector, sector);
			fail_count++;
		end
		if (source_offset !== e.source_offset) begin
			$error("source_offset: expected %0h, got %0h", e.source_offset, source_offset);
			fail_count++;
		end
		if (target_address !== e.target_address) begin
			$error("target_address: expected %0h, got %0h", e.target_address, target_address);
			fail_count++;
		end
		if (byte_count !== e.byte_count) begin
			$error("byte_count: expected %0h, got %0h", e.byte_count, byte_count);
			fail_count++;
		end
		if (accepted_length !== e.accepted_length) begin
			$error("accepted_length: expected %0h, got %0h", e.accepted_length,
				accepted_length);
			fail_count++;
		end
		if (last !== e.last) begin
			$error("last: expected %0b, got %0b", e.last, last);
			fail_count++;
		end
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload = 16'd360;
			flags = 0;
			c_off = 0;
			c_len = 0;
			remaining = 0;
			retries = 0;
			wanted = SECTOR_RESET;
			head = SECTOR_RESET;
			delivered = 0;
			wdog = 0;
			daddr = 0;
			paused = 0;
			armed = 0;
			awaited.delete();
			pending <= 0;
			head_hint <= SECTOR_RESET;
		end else begin
			if (cfg_we)
				reload = cfg_data;
			if (in_valid && in_ready)
				predict();
			if (out_valid && out_ready)
				compare();
			pending <= awaited.size();
			head_hint <= head;
		end
	end
endmodule

// ----- tb/cd_sector_read_sequencer_test.sv -----
// Testbench top for the sector read sequencer: clock, reset, reload writes,
// directed and random requests, output stalls and the verdict.
// Depends on cdsrs_pkg, cd_sector_read_sequencer and its checker.
`timescale 1ns / 100ps
module cd_sector_read_sequencer_test;
	import cdsrs_pkg::*;

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic [1:0]  mode;
	logic [23:0] file_start_sector, header_sector;
	logic [29:0] file_size, read_offset, request_length;
	logic [31:0] dest_address;
	logic        from_completion_context, drive_error;
	logic [2:0]  interrupt_kind;
	logic        cfg_we;
	logic [15:0] cfg_data;
	logic [3:0]  action;
	logic [23:0] sector;
	logic [10:0] source_offset;
	logic [31:0] target_address;
	logic [11:0] byte_count;
	logic [29:0] accepted_length;
	logic        last;
	int          fail_count, pending;
	logic [23:0] head_hint;
	bit          calm, hold_req;

	cd_sector_read_sequencer dut (.*);
	cd_sector_read_sequencer_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("cd_sector_read_sequencer_test failed");
		$finish;
	end

	initial begin
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (300) @(posedge clk);
				hold_req = 0;
			end
			out_ready <= calm || $urandom_range(0, 99) >= 26;
		end
	end

	function automatic cdsrs_evt_t noise();
		cdsrs_evt_t e;
		e.mode = 2'($urandom);
		e.file_start_sector = 24'($urandom);
		e.file_size = 30'($urandom);
		e.read_offset = 30'($urandom);
		e.request_length = 30'($urandom);
		e.dest_address = $urandom;
		e.from_completion_context = 1'($urandom);
		e.interrupt_kind = 3'($urandom);
		e.drive_error = 1'($urandom);
		e.header_sector = 24'($urandom);
		e.room = 0;
		return e;
	endfunction

	task automatic send(cdsrs_evt_t e, bit sync);
		if (sync || (!calm && $urandom_range(0, 99) < 26)) begin
			in_valid <= 0;
			repeat (sync ? 1 : $urandom_range(1, 4)) @(posedge clk);
		end
		if (sync && e.mode == MODE_IRQ)
			e.header_sector = head_hint;
		if (sync && e.mode == MODE_READ)
			e.file_start_sector = head_hint - 24'(e.read_offset[29:11]);
		in_valid <= 1;
		mode <= e.mode;
		file_start_sector <= e.file_start_sector;
		file_size <= e.file_size;
		read_offset <= e.read_offset;
		request_length <= e.request_length;
		dest_address <= e.dest_address;
		from_completion_context <= e.from_completion_context;
		interrupt_kind <= e.interrupt_kind;
		drive_error <= e.drive_error;
		header_sector <= e.header_sector;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_and_write(logic [15:0] v);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// read request followed by mostly matching data-ready interrupts
	task automatic transfer(output int cnt);
		cdsrs_evt_t e;
		int n;
		bit hit;
		e = noise();
		e.mode = MODE_READ;
		e.drive_error = 0;
		e.file_size = 30'($urandom_range(0, 20000));
		e.read_offset = 30'($urandom_range(0, 22000));
		e.request_length = 30'($urandom_range(0, 9000));
		hit = $urandom_range(0, 2) == 0;
		send(e, hit);
		n = $urandom_range(3, 9);
		cnt = n + 1;
		repeat (n) begin
			e = noise();
			e.mode = MODE_IRQ;
			e.drive_error = $urandom_range(0, 19) == 0;
			if ($urandom_range(0, 99) < 70) begin
				e.interrupt_kind = IRQ_DATA;
				send(e, $urandom_range(0, 9) != 0);
			end else begin
				if ($urandom_range(0, 3) == 0)
					e.mode = 2'($urandom_range(MODE_TICK, MODE_STOP));
				send(e, 0);
			end
		end
	endtask

	task automatic random_phase(int items);
		int sent;
		int cnt;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 3) == 0) begin
				send(noise(), 0);
				sent++;
			end else begin
				transfer(cnt);
				sent += cnt;
			end
		end
	endtask

	initial begin
		cdsrs_evt_t e;
		arst_n = 0;
		in_valid = 0;
		cfg_we = 0;
		cfg_data = 0;
		{mode, file_start_sector, file_size, read_offset, request_length} = '0;
		{dest_address, from_completion_context, interrupt_kind, drive_error} = '0;
		header_sector = 0;
		calm = 0;
		hold_req = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reload of one, extremes, every event kind
		cfg_we <= 1;
		cfg_data <= 16'd1;
		@(posedge clk);
		cfg_we <= 0;
		e = '0;
		e.mode = MODE_TICK;
		send(e, 0);
		e.mode = MODE_READ;
		e.file_size = 30'd100;
		e.read_offset = 30'd200;
		e.request_length = '1;
		send(e, 0);
		e = '1;
		e.drive_error = 0;
		send(e, 0);
		e.mode = MODE_TICK;
		send(e, 0);
		send(e, 0);
		for (int k = 0; k < 8; k++) begin
			e = '0;
			e.mode = MODE_IRQ;
			e.interrupt_kind = 3'(k);
			send(e, 0);
		end
		e = '0;
		e.mode = MODE_READ;
		e.file_size = 30'd6000;
		e.read_offset = 30'd2047;
		e.request_length = 30'd5000;
		e.dest_address = '1;
		send(e, 0);
		e.mode = MODE_IRQ;
		e.interrupt_kind = IRQ_DATA;
		e.header_sector = '1;
		repeat (5) send(e, 0);
		e.interrupt_kind = IRQ_DONE;
		send(e, 0);
		e.interrupt_kind = IRQ_ERROR;
		send(e, 0);
		e.interrupt_kind = IRQ_DATA;
		send(e, 1);
		e.mode = MODE_STOP;
		send(e, 0);
		e.mode = MODE_IRQ;
		send(e, 1);
		e.drive_error = 1;
		send(e, 0);

		drain_and_write(16'hFFFF);
		random_phase(90);

		hold_req = 1;
		repeat (20) send(noise(), 0);

		drain_and_write(16'd3);
		calm = 1;
		random_phase(90);
		calm = 0;

		drain_and_write(16'd360);
		random_phase(90);

		drain_and_write(16'($urandom_range(1, 65535)));
		random_phase(50);

		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("cd_sector_read_sequencer_test passed");
		else
			$display("cd_sector_read_sequencer_test failed");
		$finish;
	end
endmodule
